// File: sv/bnp_pkg.sv
// Shared types, constants and sizing helpers for the noise pyramid block.
`default_nettype none
package bnp_pkg;

   localparam logic [31:0] LCG_MUL = 32'd1664525;
   localparam logic [31:0] LCG_ADD = 32'd1013904223;
   localparam logic [31:0] GOLDEN  = 32'h9E3779B9;

   localparam int CSR_IW = 3;
   typedef enum logic [CSR_IW-1:0] {
      CSR_SEED        = 3'd0,
      CSR_LEVELS      = 3'd1,
      CSR_PASSES      = 3'd2,
      CSR_ROUND_SHIFT = 3'd3,
      CSR_WEIGHTS_LO  = 3'd4,
      CSR_WEIGHTS_HI  = 3'd5
   } csr_idx_type;

   localparam logic CMD_START = 1'b0;
   localparam logic CMD_FETCH = 1'b1;

   typedef enum logic [4:0] {
      ST_IDLE, ST_PLAN, ST_LVL, ST_SALT0, ST_SALT1, ST_SALT2, ST_ROW0, ST_ROW1,
      ST_H0, ST_H1, ST_H2, ST_H3, ST_H4, ST_H5, ST_H6, ST_H7, ST_H8, ST_H9, ST_H10,
      ST_AD0, ST_AD1, ST_AD2, ST_T0, ST_T1, ST_T2, ST_T3, ST_PK0, ST_PK1, ST_F0, ST_F1
   } state_type;

   typedef struct packed {
      logic [31:0] seed;
      logic [3:0]  levels;
      logic [2:0]  passes;
      logic [4:0]  round_shift;
      logic [63:0] weights_low;
      logic [63:0] weights_high;
   } cfg_type;

   typedef struct packed {
      logic        cmd;
      logic [63:0] origin_x;
      logic [63:0] origin_y;
      logic [6:0]  width;
      logic [6:0]  height;
   } req_type;

   typedef struct packed {
      logic        load;
      logic [31:0] sample;
      logic        last;
   } out_type;

   function automatic int store_depth(int side, int passes, int levels);
      int total;
      int qw;
      int pw;
      total = 0;
      qw = side;
      for (int k = 0; k < levels; k++) begin
         pw = qw + 2 * passes;
         total = total + pw * pw;
         qw = (pw + 1) >> 1;
      end
      return total;
   endfunction

endpackage
`default_nettype wire

// File: sv/bnp_mul.sv
// Shared registered 33x33 signed multiplier, low 64 product bits kept.
`default_nettype none
module bnp_mul (
   input  wire logic               clock,
   input  wire logic signed [32:0] op_a,
   input  wire logic signed [32:0] op_b,
   output logic [63:0]             prod_ff
);
   logic signed [65:0] prod_in;

   assign prod_in = op_a * op_b;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in[63:0];
   end
endmodule
`default_nettype wire

// File: sv/bnp_seq.sv
// Sequencer, level store and fetch path of the noise pyramid.
`default_nettype none
module bnp_seq #(
   parameter int MAX_LEVELS = 8,
   parameter int MAX_PASSES = 4,
   parameter int MAX_SIDE   = 64
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire bnp_pkg::cfg_type  cfg,
   input  wire logic              take,
   input  wire bnp_pkg::req_type  req,
   output logic                   idle,
   input  wire logic              out_free,
   output bnp_pkg::out_type       out
);
   import bnp_pkg::*;

   localparam int DEPTH = store_depth(MAX_SIDE, MAX_PASSES, MAX_LEVELS);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int SW = $clog2(MAX_SIDE + 2 * MAX_PASSES + 1);
   localparam int LW = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
   localparam int RW = $clog2(MAX_PASSES + 1);

   state_type state_ff, state_in;

   logic [LW-1:0] k_ff, k_in, lastk_ff, lastk_in;
   logic [RW-1:0] r_ff, r_in, pass_ff, pass_in;
   logic [63:0]   qx_ff, qx_in, qy_ff, qy_in;
   logic [SW-1:0] qw_ff, qw_in, qh_ff, qh_in;
   logic [AW:0]   tot_ff, tot_in;

   logic [63:0]   lox_ff [MAX_LEVELS];
   logic [63:0]   loy_ff [MAX_LEVELS];
   logic [SW-1:0] lqw_ff [MAX_LEVELS];
   logic [SW-1:0] lqh_ff [MAX_LEVELS];
   logic [AW-1:0] loff_ff [MAX_LEVELS];
   logic          plan_we;

   logic [63:0]   cpx_ff, cpx_in, cpy_ff, cpy_in;
   logic [SW-1:0] cqw_ff, cqw_in, cqh_ff, cqh_in, pqw_ff, pqw_in, pqh_ff, pqh_in;
   logic [AW-1:0] coff_ff, coff_in, poff_ff, poff_in;

   logic [31:0]   zl_ff, zl_in, yl_ff, yl_in, xs_ff, xs_in, ys_ff, ys_in, zs_ff, zs_in;
   logic [31:0]   x32_ff, x32_in, y32_ff, y32_in;
   logic [SW-1:0] ci_ff, ci_in, cj_ff, cj_in, cw_ff, cw_in, ch_ff, ch_in;
   logic [AW-1:0] addr_ff, addr_in, addr2_ff, addr2_in, rowp_ff, rowp_in;
   logic          vert_ff, vert_in, ready_ff, ready_in;
   logic [63:0]   acc_ff, acc_in;
   logic [SW-1:0] w0_ff, w0_in, h0_ff, h0_in, frow_ff, frow_in, fcol_ff, fcol_in;
   logic [AW-1:0] fptr_ff, fptr_in;

   logic [63:0]   mem [DEPTH];
   logic [63:0]   rdata_ff;
   logic          mem_we, mem_re;
   logic [AW-1:0] mem_waddr, mem_raddr;
   logic [63:0]   mem_wdata;

   logic signed [32:0] op_a, op_b;
   logic [63:0]   prod;

   logic [SW-1:0] w_cl, h_cl, r2, cpw, cph, pw_p, ph_p, t_cols, t_rows;
   logic [SW:0]   qw_ext, qh_ext;
   logic [RW-1:0] r_cl;
   logic [LW-1:0] lk_cl;
   logic [63:0]   px_p, py_p, wsel, vsum, hsum, half, fsum;
   logic [15:0]   weight;
   logic [2:0]    k3;
   logic [31:0]   t6;
   logic [AW-1:0] tap;
   logic          fill_col_last, fill_row_last, ad_col_last, ad_row_last;
   logic          t_col_last, t_row_last, pass_last, pk_col_last, pk_row_last;
   logic          f_col_last, f_last;

   bnp_mul u_mul (
      .clock   (clock),
      .op_a    (op_a),
      .op_b    (op_b),
      .prod_ff (prod)
   );

   always_comb begin
      if (req.width == 7'd0) w_cl = SW'(1);
      else if (32'(req.width) > MAX_SIDE) w_cl = SW'(MAX_SIDE);
      else w_cl = SW'(req.width);
      if (req.height == 7'd0) h_cl = SW'(1);
      else if (32'(req.height) > MAX_SIDE) h_cl = SW'(MAX_SIDE);
      else h_cl = SW'(req.height);
      if (cfg.passes == 3'd0) r_cl = RW'(1);
      else if (32'(cfg.passes) > MAX_PASSES) r_cl = RW'(MAX_PASSES);
      else r_cl = RW'(cfg.passes);
      if (cfg.levels == 4'd0) lk_cl = '0;
      else if (32'(cfg.levels) > MAX_LEVELS) lk_cl = LW'(MAX_LEVELS - 1);
      else lk_cl = LW'(cfg.levels - 4'd1);
   end

   assign r2   = SW'(r_ff) + SW'(r_ff);
   assign cpw  = cqw_ff + r2;
   assign cph  = cqh_ff + r2;
   assign pw_p = qw_ff + r2;
   assign ph_p = qh_ff + r2;
   assign px_p = qx_ff - 64'(r_ff);
   assign py_p = qy_ff - 64'(r_ff);
   assign qw_ext = ({1'b0, pw_p} + (SW+1)'(1) - (SW+1)'(px_p[0])) >> 1;
   assign qh_ext = ({1'b0, ph_p} + (SW+1)'(1) - (SW+1)'(py_p[0])) >> 1;

   assign k3     = 3'(k_ff);
   assign wsel   = k3[2] ? cfg.weights_high : cfg.weights_low;
   assign weight = wsel[{k3[1:0], 4'b0} +: 16];
   assign t6     = zl_ff + prod[31:0];
   assign tap    = vert_ff ? AW'(cpw) : AW'(1);
   assign hsum   = acc_ff + rdata_ff;
   assign vsum   = acc_ff + rdata_ff + 64'd8;
   assign half   = (cfg.round_shift == 5'd0) ? 64'd0 :
                   (64'd1 << (cfg.round_shift - 5'd1));
   assign fsum   = rdata_ff + half;

   assign t_cols = vert_ff ? cw_ff : cw_ff - SW'(2);
   assign t_rows = vert_ff ? ch_ff - SW'(2) : ch_ff;

   assign fill_col_last = (ci_ff == cpw - SW'(1));
   assign fill_row_last = (cj_ff == cph - SW'(1));
   assign ad_col_last   = (ci_ff == pqw_ff - SW'(1));
   assign ad_row_last   = (cj_ff == pqh_ff - SW'(1));
   assign t_col_last    = (ci_ff == t_cols - SW'(1));
   assign t_row_last    = (cj_ff == t_rows - SW'(1));
   assign pass_last     = (pass_ff == r_ff - RW'(1));
   assign pk_col_last   = (ci_ff == w0_ff - SW'(1));
   assign pk_row_last   = (cj_ff == h0_ff - SW'(1));
   assign f_col_last    = (fcol_ff == w0_ff - SW'(1));
   assign f_last        = f_col_last && (frow_ff == h0_ff - SW'(1));

   assign idle = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (take) begin
               if (req.cmd == CMD_START) state_in = ST_PLAN;
               else if (ready_ff) state_in = ST_F0;
            end
         end
         ST_PLAN:  if (k_ff == lastk_ff) state_in = ST_LVL;
         ST_LVL:   state_in = ST_SALT0;
         ST_SALT0: state_in = ST_SALT1;
         ST_SALT1: state_in = ST_SALT2;
         ST_SALT2: state_in = ST_ROW0;
         ST_ROW0:  state_in = ST_ROW1;
         ST_ROW1:  state_in = ST_H0;
         ST_H0:    state_in = ST_H1;
         ST_H1:    state_in = ST_H2;
         ST_H2:    state_in = ST_H3;
         ST_H3:    state_in = ST_H4;
         ST_H4:    state_in = ST_H5;
         ST_H5:    state_in = ST_H6;
         ST_H6:    state_in = ST_H7;
         ST_H7:    state_in = ST_H8;
         ST_H8:    state_in = ST_H9;
         ST_H9:    state_in = ST_H10;
         ST_H10: begin
            if (!fill_col_last) state_in = ST_H0;
            else if (!fill_row_last) state_in = ST_ROW0;
            else state_in = (k_ff != lastk_ff) ? ST_AD0 : ST_T0;
         end
         ST_AD0: state_in = ST_AD1;
         ST_AD1: state_in = ST_AD2;
         ST_AD2: state_in = (ad_col_last && ad_row_last) ? ST_T0 : ST_AD0;
         ST_T0:  state_in = ST_T1;
         ST_T1:  state_in = ST_T2;
         ST_T2:  state_in = ST_T3;
         ST_T3: begin
            if (t_col_last && t_row_last && vert_ff && pass_last)
               state_in = (k_ff == '0) ? ST_PK0 : ST_LVL;
            else
               state_in = ST_T0;
         end
         ST_PK0: state_in = ST_PK1;
         ST_PK1: state_in = (pk_col_last && pk_row_last) ? ST_IDLE : ST_PK0;
         ST_F0:  state_in = ST_F1;
         ST_F1:  if (out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      k_in = k_ff; lastk_in = lastk_ff; r_in = r_ff; pass_in = pass_ff;
      qx_in = qx_ff; qy_in = qy_ff; qw_in = qw_ff; qh_in = qh_ff; tot_in = tot_ff;
      cpx_in = cpx_ff; cpy_in = cpy_ff; cqw_in = cqw_ff; cqh_in = cqh_ff; coff_in = coff_ff;
      pqw_in = pqw_ff; pqh_in = pqh_ff; poff_in = poff_ff;
      zl_in = zl_ff; yl_in = yl_ff; xs_in = xs_ff; ys_in = ys_ff; zs_in = zs_ff;
      x32_in = x32_ff; y32_in = y32_ff;
      ci_in = ci_ff; cj_in = cj_ff; cw_in = cw_ff; ch_in = ch_ff;
      addr_in = addr_ff; addr2_in = addr2_ff; rowp_in = rowp_ff;
      vert_in = vert_ff; ready_in = ready_ff; acc_in = acc_ff;
      w0_in = w0_ff; h0_in = h0_ff; frow_in = frow_ff; fcol_in = fcol_ff; fptr_in = fptr_ff;
      plan_we = 1'b0;
      mem_we = 1'b0; mem_waddr = addr_ff; mem_wdata = prod;
      mem_re = 1'b0; mem_raddr = addr_ff;
      op_a = '0; op_b = '0;
      out.load = 1'b0;
      out.sample = 32'($signed(fsum) >>> cfg.round_shift);
      out.last = f_last;
      unique case (state_ff)
         ST_IDLE: begin
            if (take && req.cmd == CMD_START) begin
               qx_in = req.origin_x; qy_in = req.origin_y;
               qw_in = w_cl; qh_in = h_cl; w0_in = w_cl; h0_in = h_cl;
               k_in = '0; tot_in = '0; r_in = r_cl; lastk_in = lk_cl;
               ready_in = 1'b0;
            end
         end
         ST_PLAN: begin
            plan_we = 1'b1;
            tot_in = tot_ff + (AW+1)'(pw_p) * (AW+1)'(ph_p);
            qx_in = 64'($signed(px_p + 64'd1) >>> 1);
            qy_in = 64'($signed(py_p + 64'd1) >>> 1);
            qw_in = qw_ext[SW-1:0];
            qh_in = qh_ext[SW-1:0];
            if (k_ff != lastk_ff) k_in = k_ff + LW'(1);
         end
         ST_LVL: begin
            pqw_in = cqw_ff; pqh_in = cqh_ff; poff_in = coff_ff;
            cpx_in = lox_ff[k_ff]; cpy_in = loy_ff[k_ff];
            cqw_in = lqw_ff[k_ff]; cqh_in = lqh_ff[k_ff]; coff_in = loff_ff[k_ff];
         end
         ST_SALT0: begin
            op_a = 33'(k_ff); op_b = {1'b0, GOLDEN};
         end
         ST_SALT1: begin
            op_a = {1'b0, prod[31:0] ^ cfg.seed}; op_b = {1'b0, LCG_MUL};
         end
         ST_SALT2: begin
            zl_in = prod[31:0] + LCG_ADD;
            cj_in = '0; addr_in = coff_ff; y32_in = cpy_ff[31:0];
         end
         ST_ROW0: begin
            op_a = {1'b0, y32_ff}; op_b = {1'b0, LCG_MUL};
         end
         ST_ROW1: begin
            yl_in = prod[31:0] + LCG_ADD;
            ci_in = '0; x32_in = cpx_ff[31:0];
         end
         ST_H0: begin
            op_a = {1'b0, x32_ff}; op_b = {1'b0, LCG_MUL};
         end
         ST_H1: begin
            xs_in = prod[31:0] + LCG_ADD;
            op_a = {1'b0, yl_ff}; op_b = {1'b0, zl_ff};
         end
         ST_H2: xs_in = xs_ff + prod[31:0];
         ST_H3: begin
            op_a = {1'b0, zl_ff}; op_b = {1'b0, xs_ff};
         end
         ST_H4: ys_in = yl_ff + prod[31:0];
         ST_H5: begin
            op_a = {1'b0, xs_ff}; op_b = {1'b0, ys_ff};
         end
         ST_H6: begin
            xs_in = xs_ff ^ (xs_ff >> 16);
            ys_in = ys_ff ^ (ys_ff >> 16);
            zs_in = t6 ^ (t6 >> 16);
         end
         ST_H7: begin
            op_a = {1'b0, ys_ff}; op_b = {1'b0, zs_ff};
         end
         ST_H8: xs_in = xs_ff + prod[31:0];
         ST_H9: begin
            op_a = {~xs_ff[31], ~xs_ff[31], xs_ff[30:0]};
            op_b = {17'd0, weight};
         end
         ST_H10: begin
            mem_we = 1'b1; mem_waddr = addr_ff; mem_wdata = prod;
            addr_in = addr_ff + AW'(1);
            if (fill_col_last) begin
               ci_in = '0; cj_in = cj_ff + SW'(1); y32_in = y32_ff + 32'd1;
               if (fill_row_last) begin
                  ci_in = '0; cj_in = '0;
                  if (k_ff != lastk_ff) begin
                     addr_in = poff_ff;
                     addr2_in = coff_ff + (cpy_ff[0] ? AW'(cpw) : AW'(0))
                                + AW'(cpx_ff[0]);
                     rowp_in = addr2_in;
                  end else begin
                     pass_in = '0; vert_in = 1'b0; cw_in = cpw; ch_in = cph;
                     addr_in = coff_ff; rowp_in = coff_ff;
                  end
               end
            end else begin
               ci_in = ci_ff + SW'(1); x32_in = x32_ff + 32'd1;
            end
         end
         ST_AD0: begin
            mem_re = 1'b1; mem_raddr = addr_ff;
         end
         ST_AD1: begin
            mem_re = 1'b1; mem_raddr = addr2_ff; acc_in = rdata_ff;
         end
         ST_AD2: begin
            mem_we = 1'b1; mem_waddr = addr2_ff; mem_wdata = rdata_ff + (acc_ff << 2);
            if (ad_col_last) begin
               ci_in = '0; cj_in = cj_ff + SW'(1);
               addr_in = addr_ff + AW'(r2) + AW'(1);
               rowp_in = rowp_ff + AW'(cpw) + AW'(cpw);
               addr2_in = rowp_in;
               if (ad_row_last) begin
                  ci_in = '0; cj_in = '0;
                  pass_in = '0; vert_in = 1'b0; cw_in = cpw; ch_in = cph;
                  addr_in = coff_ff; rowp_in = coff_ff;
               end
            end else begin
               ci_in = ci_ff + SW'(1);
               addr_in = addr_ff + AW'(1);
               addr2_in = addr2_ff + AW'(2);
            end
         end
         ST_T0: begin
            mem_re = 1'b1; mem_raddr = addr_ff;
         end
         ST_T1: begin
            mem_re = 1'b1; mem_raddr = addr_ff + tap; acc_in = rdata_ff;
         end
         ST_T2: begin
            mem_re = 1'b1; mem_raddr = addr_ff + tap + tap;
            acc_in = acc_ff + (rdata_ff << 1);
         end
         ST_T3: begin
            mem_we = 1'b1; mem_waddr = addr_ff;
            mem_wdata = vert_ff ? 64'($signed(vsum) >>> 4) : hsum;
            if (t_col_last) begin
               ci_in = '0; cj_in = cj_ff + SW'(1);
               rowp_in = rowp_ff + AW'(cpw);
               addr_in = rowp_in;
               if (t_row_last) begin
                  ci_in = '0; cj_in = '0;
                  addr_in = coff_ff; rowp_in = coff_ff;
                  if (!vert_ff) begin
                     vert_in = 1'b1; cw_in = cw_ff - SW'(2);
                  end else begin
                     vert_in = 1'b0; ch_in = ch_ff - SW'(2);
                     pass_in = pass_ff + RW'(1);
                     if (pass_last) begin
                        if (k_ff == '0) begin
                           addr_in = '0; addr2_in = '0;
                        end else begin
                           k_in = k_ff - LW'(1);
                        end
                     end
                  end
               end
            end else begin
               ci_in = ci_ff + SW'(1); addr_in = addr_ff + AW'(1);
            end
         end
         ST_PK0: begin
            mem_re = 1'b1; mem_raddr = addr_ff;
         end
         ST_PK1: begin
            mem_we = 1'b1; mem_waddr = addr2_ff; mem_wdata = rdata_ff;
            addr2_in = addr2_ff + AW'(1);
            if (pk_col_last) begin
               ci_in = '0; cj_in = cj_ff + SW'(1);
               addr_in = addr_ff + AW'(r2) + AW'(1);
               if (pk_row_last) begin
                  ready_in = 1'b1; fptr_in = '0; frow_in = '0; fcol_in = '0;
               end
            end else begin
               ci_in = ci_ff + SW'(1); addr_in = addr_ff + AW'(1);
            end
         end
         ST_F0: begin
            mem_re = 1'b1; mem_raddr = fptr_ff;
         end
         ST_F1: begin
            if (out_free) begin
               out.load = 1'b1;
               fptr_in = fptr_ff + AW'(1);
               if (f_last) begin
                  ready_in = 1'b0; frow_in = '0; fcol_in = '0; fptr_in = '0;
               end else if (f_col_last) begin
                  fcol_in = '0; frow_in = frow_ff + SW'(1);
               end else begin
                  fcol_in = fcol_ff + SW'(1);
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ready_ff <= 1'b0;
         frow_ff  <= '0;
         fcol_ff  <= '0;
         fptr_ff  <= '0;
         w0_ff    <= '0;
         h0_ff    <= '0;
         k_ff     <= '0;
         lastk_ff <= '0;
         r_ff     <= RW'(1);
         pass_ff  <= '0;
         vert_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         ready_ff <= ready_in;
         frow_ff  <= frow_in;
         fcol_ff  <= fcol_in;
         fptr_ff  <= fptr_in;
         w0_ff    <= w0_in;
         h0_ff    <= h0_in;
         k_ff     <= k_in;
         lastk_ff <= lastk_in;
         r_ff     <= r_in;
         pass_ff  <= pass_in;
         vert_ff  <= vert_in;
      end
   end

   always_ff @(posedge clock) begin
      qx_ff <= qx_in; qy_ff <= qy_in; qw_ff <= qw_in; qh_ff <= qh_in; tot_ff <= tot_in;
      cpx_ff <= cpx_in; cpy_ff <= cpy_in; cqw_ff <= cqw_in; cqh_ff <= cqh_in;
      coff_ff <= coff_in; pqw_ff <= pqw_in; pqh_ff <= pqh_in; poff_ff <= poff_in;
      zl_ff <= zl_in; yl_ff <= yl_in; xs_ff <= xs_in; ys_ff <= ys_in; zs_ff <= zs_in;
      x32_ff <= x32_in; y32_ff <= y32_in;
      ci_ff <= ci_in; cj_ff <= cj_in; cw_ff <= cw_in; ch_ff <= ch_in;
      addr_ff <= addr_in; addr2_ff <= addr2_in; rowp_ff <= rowp_in; acc_ff <= acc_in;
      if (plan_we) begin
         lox_ff[k_ff]  <= px_p;
         loy_ff[k_ff]  <= py_p;
         lqw_ff[k_ff]  <= qw_ff;
         lqh_ff[k_ff]  <= qh_ff;
         loff_ff[k_ff] <= tot_ff[AW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= mem_wdata;
      if (mem_re) rdata_ff <= mem[mem_raddr];
   end

`ifndef SYNTHESIS
   a_waddr_range: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (32'(mem_waddr) < DEPTH))
      else $error("store write beyond depth");
   a_load_ready: assert property (@(posedge clock) disable iff (reset)
      out.load |-> ready_ff)
      else $error("sample produced with no field");
   a_level_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LVL) |-> (k_ff <= lastk_ff))
      else $error("level index past last level");
   a_fetch_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_F1 && $past(state_ff) == ST_F1) |-> $stable(rdata_ff))
      else $error("fetched word changed while stalled");
`endif
endmodule
`default_nettype wire

// File: sv/bandlimited_noise_pyramid_top.sv
// Top level of the band-limited noise pyramid: register file, stream ports, result register.
//
//  channel | direction | handshake            | payload
//  req     | in        | req_tvalid/tready    | tdata {height,width,origin_y,origin_x}, tuser cmd
//  rsp     | out       | rsp_tvalid/tready    | tdata sample, tlast last
//  csr     | in        | csr_valid/csr_ready  | csr_index, csr_data
//
// A start holds req_tready low until the pyramid is built: every level is planned,
// then each level, coarsest first, is filled with noise, gets the next coarser level
// added in unless it is the coarsest, and is filtered; level 0 is then packed. The one
// shared multiplier and the single store port set how long this takes. A fetch holds
// req_tready low after its transfer until its sample is loaded, which waits on any stall on rsp.
// Synchronous reset clears control state; the store holds garbage until a start.
`default_nettype none
module bandlimited_noise_pyramid_top #(
   parameter int MAX_LEVELS = 8,
   parameter int MAX_PASSES = 4,
   parameter int MAX_SIDE   = 64
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [143:0] req_tdata,   // origin_x, origin_y, width, height, zero pad
   input  wire logic         req_tuser,   // cmd
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [31:0]       rsp_tdata,   // sample
   output logic              rsp_tlast,
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [2:0]   csr_index,
   input  wire logic [63:0]  csr_data
);
   import bnp_pkg::*;

   cfg_type     cfg_ff, cfg_in;
   req_type     req;
   out_type     out;
   logic        idle, take, out_free;
   logic        rsp_tvalid_ff, rsp_tvalid_in, rsp_tlast_ff, rsp_tlast_in;
   logic [31:0] rsp_tdata_ff, rsp_tdata_in;

   assign csr_ready  = 1'b1;
   assign req_tready = idle;
   assign take       = req_tvalid && idle;
   assign out_free   = !rsp_tvalid_ff || rsp_tready;

   assign req.cmd      = req_tuser;
   assign req.origin_x = req_tdata[63:0];
   assign req.origin_y = req_tdata[127:64];
   assign req.width    = req_tdata[134:128];
   assign req.height   = req_tdata[141:135];

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_SEED:        cfg_in.seed = csr_data[31:0];
            CSR_LEVELS:      cfg_in.levels = csr_data[3:0];
            CSR_PASSES:      cfg_in.passes = csr_data[2:0];
            CSR_ROUND_SHIFT: cfg_in.round_shift = csr_data[4:0];
            CSR_WEIGHTS_LO:  cfg_in.weights_low = csr_data;
            CSR_WEIGHTS_HI:  cfg_in.weights_high = csr_data;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tlast_in  = rsp_tlast_ff;
      if (out.load) begin
         rsp_tvalid_in = 1'b1;
         rsp_tdata_in  = out.sample;
         rsp_tlast_in  = out.last;
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.seed         <= '0;
         cfg_ff.levels       <= 4'd1;
         cfg_ff.passes       <= 3'd1;
         cfg_ff.round_shift  <= '0;
         cfg_ff.weights_low  <= '0;
         cfg_ff.weights_high <= '0;
         rsp_tvalid_ff       <= 1'b0;
      end else begin
         cfg_ff        <= cfg_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_tdata_ff <= rsp_tdata_in;
      rsp_tlast_ff <= rsp_tlast_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tlast  = rsp_tlast_ff;

   bnp_seq #(
      .MAX_LEVELS (MAX_LEVELS),
      .MAX_PASSES (MAX_PASSES),
      .MAX_SIDE   (MAX_SIDE)
   ) u_seq (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .take     (take),
      .req      (req),
      .idle     (idle),
      .out_free (out_free),
      .out      (out)
   );
endmodule
`default_nettype wire
